/* rtl/differential_drive_odometry_macros.svh */
// ----------------------------------------------------------------------------
// Differential-drive odometry assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DDO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odometry port check failed");

// Next-cycle implication, disabled while reset is high.
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry port check failed");

`endif

/* rtl/dd_odo_pkg.sv */
// ----------------------------------------------------------------------------
// dd_odo_pkg
// Types, constants and tables shared by the odometry modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dd_odo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int POS_WIDTH    = 48;

   localparam int SPEED_W      = 16;
   localparam int ANGLE_W      = 32;
   localparam int CFG_W        = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CV_W         = 34;   // CORDIC vector and angle width
   localparam int DIVIDEND_W   = 46;   // turn magnitude with 16 low bits removed
   localparam int DIVISOR_W    = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS + 1);
   localparam int DIV_CNT_W    = $clog2(DIVIDEND_W + 1);

   localparam logic [29:0]     TURN_PER_RAD    = 30'd683565276;
   localparam logic [CV_W-1:0] CORDIC_INV_GAIN = CV_W'(652032874);

   localparam logic [15:0]        WHEEL_BASE_RESET = 16'd100;
   localparam logic [15:0]        STEP_TIME_RESET  = 16'd1311;
   localparam logic [ANGLE_W-1:0] HEADING_RESET    = 32'd357913941;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WHEEL_BASE   = 2'd0,
      CSR_STEP_TIME    = 2'd1,
      CSR_INIT_HEADING = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MAG0, S_MAG1, S_DIST, S_DIV, S_HEAD,
      S_CORD, S_MULX, S_ADDX, S_MULY, S_ADDY, S_OUT
   } state_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] right_speed;
      logic signed [SPEED_W-1:0] left_speed;
   } req_payload_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] pos_x;
      logic signed [POS_WIDTH-1:0] pos_y;
   } rsp_payload_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quot;
      logic [DIVISOR_W-1:0]  rem;
   } div_res_type;

   typedef struct packed {
      logic                   done;
      logic signed [CV_W-1:0] cos_val;
      logic signed [CV_W-1:0] sin_val;
   } cordic_res_type;

   // Arctangent of 2^-k as a 32-bit binary angle.
   function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] k);
      logic [ANGLE_W-1:0] a;
      case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

/* rtl/dd_odo_div.sv */
// ----------------------------------------------------------------------------
// dd_odo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_odo_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [dd_odo_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [dd_odo_pkg::DIVISOR_W-1:0]  divisor,
   output dd_odo_pkg::div_res_type                res
);
   import dd_odo_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] qd_ff, qd_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, qd_ff[DIVIDEND_W-1]};
      fits    = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qd_in   = qd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         qd_in   = dividend;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
         qd_in  = {qd_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
   end

   assign res.done = done_ff;
   assign res.quot = qd_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

/* rtl/dd_odo_cordic.sv */
// ----------------------------------------------------------------------------
// dd_odo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_odo_cordic (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [dd_odo_pkg::ANGLE_W-1:0] angle,
   output dd_odo_pkg::cordic_res_type          res
);
   import dd_odo_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   flip_ff, flip_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic signed [CV_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0]             k;
   logic signed [CV_W-1:0] xs, ys, at;
   logic [ANGLE_W-1:0]     folded;

   always_comb begin
      k       = 5'(iter_ff);
      xs      = x_ff >>> k;
      ys      = y_ff >>> k;
      at      = signed'(CV_W'(atan_entry(k)));
      folded  = angle;
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         // fold second and third quadrants by a half turn
         flip_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
         folded  = {angle[ANGLE_W-1] ^ flip_in, angle[ANGLE_W-2:0]};
         x_in    = CORDIC_INV_GAIN;
         y_in    = '0;
         z_in    = CV_W'(signed'(folded));
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CV_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign res.done    = done_ff;
   assign res.cos_val = flip_ff ? -x_ff : x_ff;
   assign res.sin_val = flip_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

/* rtl/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Midpoint-rule odometry: wheel speeds in, new x/y position out.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | beat carries
//   ---------+-----------+--------------------+------------------------------
//   req_     | in        | req_valid/stall    | right_speed, left_speed
//   rsp_     | out       | rsp_valid/stall    | pos_x, pos_y (Q.16 mm)
//   csr_     | in        | csr_wr_en          | index, write data
//
// A beat runs from acceptance to a valid result through the bit-serial turn
// divider and the CORDIC iterations, and its products are taken in turn on
// the shared 32x32 multiplier. No new beat is taken while one is in work.
// req_stall stays high from acceptance until the result is in the output
// register. A stalled result holds; the next beat is accepted meanwhile and
// waits only at the final load. Reset is synchronous, clears the position and
// loads the reset heading.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire dd_odo_pkg::req_payload_type         req_payload,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      dd_odo_pkg::rsp_payload_type         rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [dd_odo_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dd_odo_pkg::CFG_W-1:0]        csr_wdata
);
   import dd_odo_pkg::*;

   // Saturation is done one headroom bit above the wider of pose and step.
   localparam int SUM_W = ((POS_WIDTH > 34) ? POS_WIDTH : 34) + 1;

   state_type state_ff, state_in;

   // configuration
   logic [15:0]        wheel_base_ff, step_time_ff;

   // pose
   logic signed [POS_WIDTH-1:0] pose_x_ff, pose_y_ff;
   logic [ANGLE_W-1:0]          heading_ff;

   // working registers
   req_payload_type req_ff;
   logic [63:0]     prod_ff;
   logic [15:0]     mag_lo_ff;
   logic [31:0]     d2_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;

   logic               accept;
   logic signed [16:0] diff, sum;
   logic [15:0]        adiff;
   logic [16:0]        asum;
   logic [15:0]        base_eff;
   logic               div_start, cordic_start;
   div_res_type        div_res;
   cordic_res_type     cordic_res;

   logic               round_up;
   logic [ANGLE_W-1:0] full, half, mid;
   logic [33:0]        q_plus;

   logic signed [CV_W-1:0] trig;
   logic [CV_W-1:0]        trig_mag;
   logic                   disp_neg;
   logic [63:0]            rounded;
   logic signed [SUM_W-1:0] disp, pose_sel, pose_sum;
   logic signed [POS_WIDTH-1:0] pose_sat;
   logic                   rsp_load;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign base_eff  = (wheel_base_ff == 16'd0) ? 16'd1 : wheel_base_ff;

   always_comb begin
      diff  = 17'(req_ff.right_speed) - 17'(req_ff.left_speed);
      sum   = 17'(req_ff.right_speed) + 17'(req_ff.left_speed);
      adiff = diff[16] ? 16'(-diff) : diff[15:0];
      asum  = sum[16] ? 17'(-sum) : 17'(sum);
   end

   // operand select for the one multiplier
   always_comb begin
      trig     = (state_ff == S_MULY || state_ff == S_ADDY) ? cordic_res.sin_val
                                                            : cordic_res.cos_val;
      trig_mag = trig[CV_W-1] ? CV_W'(-trig) : CV_W'(trig);
      case (state_ff)
         S_MAG0: begin
            mul_a = 32'(adiff);
            mul_b = 32'(step_time_ff);
         end
         S_MAG1: begin
            mul_a = prod_ff[31:0];
            mul_b = 32'(TURN_PER_RAD);
         end
         S_DIST: begin
            mul_a = 32'(asum);
            mul_b = 32'(step_time_ff);
         end
         default: begin
            mul_a = d2_ff;
            mul_b = trig_mag[31:0];
         end
      endcase
      product = 64'(mul_a) * 64'(mul_b);
   end

   // heading update: round the quotient to nearest, derive the half turn
   always_comb begin
      round_up = ({div_res.rem, mag_lo_ff} >= {1'b0, base_eff, 15'd0});
      full     = div_res.quot[ANGLE_W-1:0] + ANGLE_W'(round_up);
      q_plus   = {1'b0, div_res.quot[32:0]} + 34'd1;
      half     = q_plus[32:1];
      if (diff[16]) begin
         full = -full;
         half = -half;
      end
      mid = heading_ff + half;
   end

   // displacement: round(|d2| * |c| / 2^31), then sign and saturate
   always_comb begin
      disp_neg = sum[16] ^ trig[CV_W-1];
      rounded  = (prod_ff + 64'h40000000) >> 31;
      disp     = disp_neg ? -SUM_W'(signed'({1'b0, rounded[32:0]}))
                          :  SUM_W'(signed'({1'b0, rounded[32:0]}));
      pose_sel = (state_ff == S_ADDY) ? SUM_W'(pose_y_ff) : SUM_W'(pose_x_ff);
      pose_sum = pose_sel + disp;
      if (pose_sum[SUM_W-1:POS_WIDTH-1] == '0 ||
          pose_sum[SUM_W-1:POS_WIDTH-1] == '1) begin
         pose_sat = pose_sum[POS_WIDTH-1:0];
      end else if (pose_sum[SUM_W-1]) begin
         pose_sat = {1'b1, {(POS_WIDTH-1){1'b0}}};
      end else begin
         pose_sat = {1'b0, {(POS_WIDTH-1){1'b1}}};
      end
   end

   assign div_start    = (state_ff == S_DIST);
   assign cordic_start = (state_ff == S_HEAD);
   assign rsp_load     = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_MAG0;
         S_MAG0: state_in = S_MAG1;
         S_MAG1: state_in = S_DIST;
         S_DIST: state_in = S_DIV;
         S_DIV:  if (div_res.done) state_in = S_HEAD;
         S_HEAD: state_in = S_CORD;
         S_CORD: if (cordic_res.done) state_in = S_MULX;
         S_MULX: state_in = S_ADDX;
         S_ADDX: state_in = S_MULY;
         S_MULY: state_in = S_ADDY;
         S_ADDY: state_in = S_OUT;
         S_OUT:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration, pose and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_base_ff   <= WHEEL_BASE_RESET;
         step_time_ff    <= STEP_TIME_RESET;
         heading_ff      <= HEADING_RESET;
         pose_x_ff       <= '0;
         pose_y_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (state_ff == S_HEAD) heading_ff <= heading_ff + full;
         if (state_ff == S_ADDX) pose_x_ff <= pose_sat;
         if (state_ff == S_ADDY) pose_y_ff <= pose_sat;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WHEEL_BASE:   wheel_base_ff <= csr_wdata[15:0];
               CSR_STEP_TIME:    step_time_ff  <= csr_wdata[15:0];
               CSR_INIT_HEADING: begin
                  // load the heading at once
                  heading_ff      <= csr_wdata[ANGLE_W-1:0];
               end
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_payload;
      case (state_ff)
         S_MAG0, S_MAG1, S_MULX, S_MULY: prod_ff <= product;
         S_DIST: begin
            mag_lo_ff <= prod_ff[15:0];
            d2_ff     <= product[31:0];
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_payload_ff.pos_x <= pose_x_ff;
         rsp_payload_ff.pos_y <= pose_y_ff;
      end
   end

   dd_odo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[61:16]),
      .divisor  (base_eff),
      .res      (div_res)
   );

   dd_odo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (mid),
      .res   (cordic_res)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* rtl/dd_odo_checker.sv */
// ----------------------------------------------------------------------------
// dd_odo_checker
// Port-level checks on the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "differential_drive_odometry_macros.svh"

module dd_odo_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire dd_odo_pkg::rsp_payload_type        rsp_payload
);
   import dd_odo_pkg::*;

   // busy once a beat is taken
   `DDO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a result appears only at the end of a busy stretch
   `DDO_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   // a stalled result holds
   `DDO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_payload))
   // nothing is pending out of reset
   `DDO_ASSERT_NOW(a_reset_idle, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind differential_drive_odometry dd_odo_checker u_dd_odo_checker (.*);

`default_nettype wire
